/* hdl/u64venc_pkg.sv */
// ----------------------------------------------------------------------------
// u64venc_pkg
// shared constants, codes and command/status types of the u64 field encoder
// ----------------------------------------------------------------------------
`default_nettype none

package u64venc_pkg;

   // field widths
   localparam int VALUE_WIDTH = 64;
   localparam int SEGW_WIDTH  = 4;
   localparam int SEGV_WIDTH  = 12;
   localparam int LOW_BITS    = 12;
   localparam int REM_WIDTH   = VALUE_WIDTH - LOW_BITS;
   localparam int BYTE_BITS   = 8;
   localparam int NIB_BITS    = 4;
   localparam int GRP_WIDTH   = 3;

   // byte groups before the final nibble
   localparam logic [GRP_WIDTH-1:0] MAX_GROUPS = 3'd6;

   // class boundaries
   localparam logic [VALUE_WIDTH-1:0] SMALL_MAX = 64'd16;
   localparam logic [VALUE_WIDTH-1:0] MID_MAX   = 64'd272;
   localparam logic [BYTE_BITS-1:0]   MID_BIAS  = 8'd17;
   localparam logic [NIB_BITS-1:0]    SMALL_BIAS = 4'd1;

   // segment widths
   localparam logic [SEGW_WIDTH-1:0] W_SEL   = 4'd2;
   localparam logic [SEGW_WIDTH-1:0] W_FLAG  = 4'd1;
   localparam logic [SEGW_WIDTH-1:0] W_NIB   = 4'd4;
   localparam logic [SEGW_WIDTH-1:0] W_BYTE  = 4'd8;
   localparam logic [SEGW_WIDTH-1:0] W_LOW   = 4'd12;

   // value class, equal to the selector bits
   typedef logic [1:0] cls_type;
   localparam cls_type CLS_ZERO  = 2'd0;
   localparam cls_type CLS_SMALL = 2'd1;
   localparam cls_type CLS_MID   = 2'd2;
   localparam cls_type CLS_LARGE = 2'd3;

   // segment kinds
   typedef logic [2:0] kind_type;
   localparam kind_type KIND_SEL  = 3'd0;
   localparam kind_type KIND_EXT  = 3'd1;
   localparam kind_type KIND_FLAG = 3'd2;
   localparam kind_type KIND_STOP = 3'd3;
   localparam kind_type KIND_BYTE = 3'd4;
   localparam kind_type KIND_NIB  = 3'd5;

   typedef struct packed {
      logic     load;
      logic     emit;
      kind_type kind;
      logic     last;
   } dp_cmd_type;

   typedef struct packed {
      cls_type cls;
      logic    rem_zero;
      logic    groups_full;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/u64venc_if.sv */
// ----------------------------------------------------------------------------
// u64venc channel interfaces
// valid/ready channels for input values and output segments
// ----------------------------------------------------------------------------
`default_nettype none

interface u64venc_req_if;
   logic                                valid;
   logic                                ready;
   logic [u64venc_pkg::VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface u64venc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [u64venc_pkg::SEGW_WIDTH-1:0] seg_width;
   logic [u64venc_pkg::SEGV_WIDTH-1:0] seg_value;
   logic                               seg_last;

   modport source (output valid, output seg_width, output seg_value, output seg_last,
                   input ready);
   modport sink   (input valid, input seg_width, input seg_value, input seg_last,
                   output ready);
endinterface

`default_nettype wire

/* hdl/u64_varint_field_encoder.sv */
// ----------------------------------------------------------------------------
// u64_varint_field_encoder
// splits a 64-bit unsigned value into the bit segments of its field code
// ----------------------------------------------------------------------------
// One value taken on req gives 1 to 16 segments on rsp, each a width, the
// segment bits and a last flag, in the order they go into the bitstream: a
// 2-bit selector, then nothing for zero, value-1 in 4 bits for 1..16,
// value-17 in 8 bits for 17..272, and for larger values the low 12 bits,
// up to six flag-plus-byte groups and a closing stop bit, or a flag and the
// top nibble once 60 bits are used. A value is loaded while the sequencer
// is idle, then the sequencer fills the single segment output register
// with one segment per cycle whenever that register is empty or being
// drained. The next value is taken while the last segment of the
// previous one still waits in that register.
// ----------------------------------------------------------------------------
`default_nettype none

module u64_varint_field_encoder (
   input  wire           clock,
   input  wire           reset,
   u64venc_req_if.sink   req,
   u64venc_rsp_if.source rsp
);

   // command and status between sequencer and datapath
   u64venc_pkg::dp_cmd_type    cmd;
   u64venc_pkg::dp_status_type status;

   // sequencer: walks selector, extension, flag/byte groups and the tail
   u64venc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: classifies the value, shifts out bytes, holds the segment
   u64venc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .value     (req.value),
      .seg_width (rsp.seg_width),
      .seg_value (rsp.seg_value),
      .seg_last  (rsp.seg_last)
   );

endmodule

`default_nettype wire

/* hdl/u64venc_dp.sv */
// ----------------------------------------------------------------------------
// u64venc_dp
// value classing, remainder shifter and segment output register
// ----------------------------------------------------------------------------
`default_nettype none

module u64venc_dp (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire u64venc_pkg::dp_cmd_type              cmd,
   output u64venc_pkg::dp_status_type                status,
   input  wire [u64venc_pkg::VALUE_WIDTH-1:0]        value,
   output logic [u64venc_pkg::SEGW_WIDTH-1:0]        seg_width,
   output logic [u64venc_pkg::SEGV_WIDTH-1:0]        seg_value,
   output logic                                      seg_last
);

   u64venc_pkg::cls_type                cls_ff, cls_in;
   logic [u64venc_pkg::SEGV_WIDTH-1:0]  ext_ff, ext_in;
   logic [u64venc_pkg::REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [u64venc_pkg::GRP_WIDTH-1:0]   grp_ff, grp_in;
   logic [u64venc_pkg::SEGW_WIDTH-1:0]  seg_width_ff, seg_width_in;
   logic [u64venc_pkg::SEGV_WIDTH-1:0]  seg_value_ff, seg_value_in;
   logic                                seg_last_ff, seg_last_in;
   u64venc_pkg::cls_type                load_cls;
   logic [u64venc_pkg::SEGV_WIDTH-1:0]  load_ext;
   logic [u64venc_pkg::SEGW_WIDTH-1:0]  ext_width;
   logic [u64venc_pkg::NIB_BITS-1:0]    small_ext;
   logic [u64venc_pkg::BYTE_BITS-1:0]   mid_ext;

   // bias subtraction wraps at the segment width
   assign small_ext = value[u64venc_pkg::NIB_BITS-1:0] - u64venc_pkg::SMALL_BIAS;
   assign mid_ext   = value[u64venc_pkg::BYTE_BITS-1:0] - u64venc_pkg::MID_BIAS;

   // classify the incoming value and precompute the second segment
   always_comb begin
      if (value == '0) begin
         load_cls = u64venc_pkg::CLS_ZERO;
         load_ext = '0;
      end else if (value <= u64venc_pkg::SMALL_MAX) begin
         load_cls = u64venc_pkg::CLS_SMALL;
         load_ext = u64venc_pkg::SEGV_WIDTH'(small_ext);
      end else if (value <= u64venc_pkg::MID_MAX) begin
         load_cls = u64venc_pkg::CLS_MID;
         load_ext = u64venc_pkg::SEGV_WIDTH'(mid_ext);
      end else begin
         load_cls = u64venc_pkg::CLS_LARGE;
         load_ext = value[u64venc_pkg::LOW_BITS-1:0];
      end
   end

   always_comb begin
      unique case (cls_ff)
         u64venc_pkg::CLS_SMALL: ext_width = u64venc_pkg::W_NIB;
         u64venc_pkg::CLS_MID:   ext_width = u64venc_pkg::W_BYTE;
         default:                ext_width = u64venc_pkg::W_LOW;
      endcase
   end

   always_comb begin
      cls_in = cls_ff;
      ext_in = ext_ff;
      rem_in = rem_ff;
      grp_in = grp_ff;
      if (cmd.load) begin
         cls_in = load_cls;
         ext_in = load_ext;
         rem_in = value[u64venc_pkg::VALUE_WIDTH-1:u64venc_pkg::LOW_BITS];
         grp_in = '0;
      end else if (cmd.emit && cmd.kind == u64venc_pkg::KIND_BYTE) begin
         rem_in = rem_ff >> u64venc_pkg::BYTE_BITS;
         grp_in = grp_ff + 1'b1;
      end
   end

   // segment mux into the output register
   always_comb begin
      seg_width_in = seg_width_ff;
      seg_value_in = seg_value_ff;
      seg_last_in  = seg_last_ff;
      if (cmd.emit) begin
         seg_last_in = cmd.last;
         unique case (cmd.kind)
            u64venc_pkg::KIND_SEL: begin
               seg_width_in = u64venc_pkg::W_SEL;
               seg_value_in = u64venc_pkg::SEGV_WIDTH'(cls_ff);
            end
            u64venc_pkg::KIND_EXT: begin
               seg_width_in = ext_width;
               seg_value_in = ext_ff;
            end
            u64venc_pkg::KIND_FLAG: begin
               seg_width_in = u64venc_pkg::W_FLAG;
               seg_value_in = u64venc_pkg::SEGV_WIDTH'(1'b1);
            end
            u64venc_pkg::KIND_STOP: begin
               seg_width_in = u64venc_pkg::W_FLAG;
               seg_value_in = '0;
            end
            u64venc_pkg::KIND_BYTE: begin
               seg_width_in = u64venc_pkg::W_BYTE;
               seg_value_in = u64venc_pkg::SEGV_WIDTH'(rem_ff[u64venc_pkg::BYTE_BITS-1:0]);
            end
            u64venc_pkg::KIND_NIB: begin
               seg_width_in = u64venc_pkg::W_NIB;
               seg_value_in = u64venc_pkg::SEGV_WIDTH'(rem_ff[u64venc_pkg::NIB_BITS-1:0]);
            end
            default: begin
               seg_width_in = seg_width_ff;
               seg_value_in = seg_value_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= '0;
      end else begin
         grp_ff <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff       <= cls_in;
      ext_ff       <= ext_in;
      rem_ff       <= rem_in;
      seg_width_ff <= seg_width_in;
      seg_value_ff <= seg_value_in;
      seg_last_ff  <= seg_last_in;
   end

   assign status.cls         = cls_ff;
   assign status.rem_zero    = (rem_ff == '0);
   assign status.groups_full = (grp_ff == u64venc_pkg::MAX_GROUPS);

   assign seg_width = seg_width_ff;
   assign seg_value = seg_value_ff;
   assign seg_last  = seg_last_ff;

   // group count never runs past the last byte group
   a_grp_bound: assert property (@(posedge clock) disable iff (reset)
      grp_ff <= u64venc_pkg::MAX_GROUPS)
      else $error("byte group count overflow");

   // a byte is only taken while value bits remain below the nibble
   a_byte_nonfull: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == u64venc_pkg::KIND_BYTE) |-> (grp_ff != u64venc_pkg::MAX_GROUPS))
      else $error("byte group after the sixth");

   // the selector segment carries the class of the loaded value
   a_sel_class: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (cls_ff == $past(load_cls)))
      else $error("class not captured on load");

endmodule

`default_nettype wire

/* hdl/u64venc_ctrl.sv */
// ----------------------------------------------------------------------------
// u64venc_ctrl
// segment sequencer and output valid register
// ----------------------------------------------------------------------------
`default_nettype none

module u64venc_ctrl (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output u64venc_pkg::dp_cmd_type        cmd,
   input  wire u64venc_pkg::dp_status_type status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SEL  = 3'd1;
   localparam logic [2:0] ST_EXT  = 3'd2;
   localparam logic [2:0] ST_FLAG = 3'd3;
   localparam logic [2:0] ST_BYTE = 3'd4;
   localparam logic [2:0] ST_NIB  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = u64venc_pkg::KIND_SEL;
               cmd.last = (status.cls == u64venc_pkg::CLS_ZERO);
               state_in = cmd.last ? ST_IDLE : ST_EXT;
            end
         end
         ST_EXT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = u64venc_pkg::KIND_EXT;
               cmd.last = (status.cls != u64venc_pkg::CLS_LARGE);
               state_in = cmd.last ? ST_IDLE : ST_FLAG;
            end
         end
         ST_FLAG: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (status.rem_zero) begin
                  cmd.kind = u64venc_pkg::KIND_STOP;
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.kind = u64venc_pkg::KIND_FLAG;
                  state_in = status.groups_full ? ST_NIB : ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = u64venc_pkg::KIND_BYTE;
               state_in = ST_FLAG;
            end
         end
         ST_NIB: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = u64venc_pkg::KIND_NIB;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // the final segment of a code hands control back to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer not idle after last segment");

   // the closing nibble follows only the sixth byte group
   a_nib_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == u64venc_pkg::KIND_NIB) |-> status.groups_full)
      else $error("nibble before six byte groups");

   // a zero value ends on its selector
   a_zero_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == u64venc_pkg::KIND_SEL
       && status.cls == u64venc_pkg::CLS_ZERO) |-> cmd.last)
      else $error("zero value code not closed at selector");

endmodule

`default_nettype wire
